### rtl/clb_pkg.sv
// shared types and constants of the line to box clipper
`timescale 1ns / 1ps
package clb_pkg;

   localparam int CLB_FRAC_BITS = 16;
   localparam int CLB_COORD_W   = 16;
   localparam int CLB_C_W       = 32;
   localparam int CLB_NUM_W     = 34;
   localparam int CLB_DEN_W     = 16;
   localparam int CLB_OUT_W     = 32;

   typedef struct packed {
      logic                   mag_neg;
      logic [CLB_NUM_W-1:0]   mag;
   } clb_num_type;

   typedef struct packed {
      logic                          a_nz;
      logic                          b_nz;
      logic signed [CLB_COORD_W-1:0] lx;
      logic signed [CLB_COORD_W-1:0] ly;
      logic signed [CLB_COORD_W-1:0] hx;
      logic signed [CLB_COORD_W-1:0] hy;
      logic [CLB_DEN_W-1:0]          den_a;
      logic [CLB_DEN_W-1:0]          den_b;
      clb_num_type                   num_a_lo;
      clb_num_type                   num_a_hi;
      clb_num_type                   num_b_lo;
      clb_num_type                   num_b_hi;
   } clb_item_type;

endpackage

### rtl/clb_front.sv
// front end: sorts the box, forms the numerators of the box edges
`timescale 1ns / 1ps
module clb_front
   import clb_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic signed [CLB_COORD_W-1:0] coef_a,
   input  logic signed [CLB_COORD_W-1:0] coef_b,
   input  logic signed [CLB_C_W-1:0]     coef_c,
   input  logic signed [CLB_COORD_W-1:0] c1x,
   input  logic signed [CLB_COORD_W-1:0] c1y,
   input  logic signed [CLB_COORD_W-1:0] c2x,
   input  logic signed [CLB_COORD_W-1:0] c2y,
   output logic                          out_valid,
   output clb_item_type                  out_item
);

   logic                          v1_ff, v2_ff, v3_ff;
   logic signed [CLB_COORD_W-1:0] a1_ff, b1_ff, a2_ff, b2_ff;
   logic signed [CLB_C_W-1:0]     c1_ff, c2_ff;
   logic signed [CLB_COORD_W-1:0] lx1_ff, ly1_ff, hx1_ff, hy1_ff;
   logic signed [CLB_COORD_W-1:0] lx2_ff, ly2_ff, hx2_ff, hy2_ff;
   logic signed [2*CLB_COORD_W-1:0] p_alo_ff, p_ahi_ff, p_blo_ff, p_bhi_ff;
   clb_item_type                  item_ff, item_in;

   function automatic clb_num_type mk_num(input logic signed [2*CLB_COORD_W-1:0] p,
                                          input logic signed [CLB_C_W-1:0] c,
                                          input logic den_neg);
      logic signed [CLB_NUM_W-1:0] n;
      clb_num_type r;
      n = -(CLB_NUM_W'(p) + CLB_NUM_W'(c));
      r.mag     = n[CLB_NUM_W-1] ? CLB_NUM_W'(-n) : CLB_NUM_W'(n);
      r.mag_neg = n[CLB_NUM_W-1] ^ den_neg;
      return r;
   endfunction

   function automatic logic [CLB_DEN_W-1:0] mag16(input logic signed [CLB_COORD_W-1:0] v);
      return v[CLB_COORD_W-1] ? CLB_DEN_W'(-v) : CLB_DEN_W'(v);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      // stage 1: capture beat, order the corners
      a1_ff  <= coef_a;
      b1_ff  <= coef_b;
      c1_ff  <= coef_c;
      lx1_ff <= (c1x > c2x) ? c2x : c1x;
      hx1_ff <= (c1x > c2x) ? c1x : c2x;
      ly1_ff <= (c1y > c2y) ? c2y : c1y;
      hy1_ff <= (c1y > c2y) ? c1y : c2y;
      // stage 2: products
      a2_ff    <= a1_ff;
      b2_ff    <= b1_ff;
      c2_ff    <= c1_ff;
      lx2_ff   <= lx1_ff;
      ly2_ff   <= ly1_ff;
      hx2_ff   <= hx1_ff;
      hy2_ff   <= hy1_ff;
      p_alo_ff <= b1_ff * ly1_ff;
      p_ahi_ff <= b1_ff * hy1_ff;
      p_blo_ff <= a1_ff * lx1_ff;
      p_bhi_ff <= a1_ff * hx1_ff;
      // stage 3: numerators
      item_ff  <= item_in;
   end

   always_comb begin
      item_in.a_nz     = (a2_ff != '0);
      item_in.b_nz     = (b2_ff != '0);
      item_in.lx       = lx2_ff;
      item_in.ly       = ly2_ff;
      item_in.hx       = hx2_ff;
      item_in.hy       = hy2_ff;
      item_in.den_a    = mag16(a2_ff);
      item_in.den_b    = mag16(b2_ff);
      item_in.num_a_lo = mk_num(p_alo_ff, c2_ff, a2_ff[CLB_COORD_W-1]);
      item_in.num_a_hi = mk_num(p_ahi_ff, c2_ff, a2_ff[CLB_COORD_W-1]);
      item_in.num_b_lo = mk_num(p_blo_ff, c2_ff, b2_ff[CLB_COORD_W-1]);
      item_in.num_b_hi = mk_num(p_bhi_ff, c2_ff, b2_ff[CLB_COORD_W-1]);
   end

   assign out_valid = v3_ff;
   assign out_item  = item_ff;

endmodule

### rtl/clb_fifo.sv
// short queue between front and back
`timescale 1ns / 1ps
module clb_fifo
   import clb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  clb_item_type push_item,
   input  logic         pop,
   output logic         not_empty,
   output logic         almost_full,
   output clb_item_type head_item
);

   localparam int DEPTH = 4;

   clb_item_type mem_ff [DEPTH];
   logic [1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [2:0]   cnt_ff, cnt_in;
   logic         do_pop;

   assign do_pop = pop && (cnt_ff != 3'd0);
   assign wr_in  = push ? wr_ff + 2'd1 : wr_ff;
   assign rd_in  = do_pop ? rd_ff + 2'd1 : rd_ff;
   assign cnt_in = cnt_ff + {2'b00, push} - {2'b00, do_pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

   assign head_item   = mem_ff[rd_ff];
   assign not_empty   = (cnt_ff != 3'd0);
   assign almost_full = (cnt_ff > 3'd1);

endmodule

### rtl/clb_div.sv
// pipelined restoring divider, one quotient bit per stage, signed result
`timescale 1ns / 1ps
module clb_div #(
   parameter int NW = 50,
   parameter int DW = 16
) (
   input  logic                clock,
   input  logic [NW-1:0]       in_num,
   input  logic [DW-1:0]       in_den,
   input  logic                in_neg,
   output logic signed [NW:0]  quo
);

   logic [DW-1:0] rem_ff [NW+1];
   logic [NW-1:0] nq_ff  [NW+1];
   logic [DW-1:0] den_ff [NW+1];
   logic          neg_ff [NW+1];
   logic signed [NW:0] quo_ff;

   always_ff @(posedge clock) begin
      rem_ff[0] <= '0;
      nq_ff[0]  <= in_num;
      den_ff[0] <= in_den;
      neg_ff[0] <= in_neg;
   end

   for (genvar s = 0; s < NW; s++) begin : g_stage
      logic [DW:0]   trial_in;
      logic          ge_in;
      logic [DW:0]   diff_in;
      assign trial_in = {rem_ff[s], nq_ff[s][NW-1]};
      assign ge_in    = trial_in >= {1'b0, den_ff[s]};
      assign diff_in  = trial_in - {1'b0, den_ff[s]};
      always_ff @(posedge clock) begin
         rem_ff[s+1] <= ge_in ? diff_in[DW-1:0] : trial_in[DW-1:0];
         nq_ff[s+1]  <= {nq_ff[s][NW-2:0], ge_in};
         den_ff[s+1] <= den_ff[s];
         neg_ff[s+1] <= neg_ff[s];
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= neg_ff[NW] ? -$signed({1'b0, nq_ff[NW]}) : $signed({1'b0, nq_ff[NW]});
   end

   assign quo = quo_ff;

endmodule

### rtl/clb_back.sv
// back end: a divider per box edge, box tests, point ordering, saturation
`timescale 1ns / 1ps
module clb_back
   import clb_pkg::*;
#(
   parameter int FRAC_BITS = CLB_FRAC_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  clb_item_type                 in_item,
   output logic                         out_valid,
   output logic                         out_hit,
   output logic signed [CLB_OUT_W-1:0]  out_bx,
   output logic signed [CLB_OUT_W-1:0]  out_by,
   output logic signed [CLB_OUT_W-1:0]  out_ex,
   output logic signed [CLB_OUT_W-1:0]  out_ey
);

   localparam int NW  = CLB_NUM_W + FRAC_BITS;
   localparam int QW  = NW + 1;
   localparam int LAT = NW + 2;
   localparam logic signed [QW-1:0] SAT_HI = {{(QW-CLB_OUT_W+1){1'b0}}, {(CLB_OUT_W-1){1'b1}}};
   localparam logic signed [QW-1:0] SAT_LO = {{(QW-CLB_OUT_W+1){1'b1}}, {(CLB_OUT_W-1){1'b0}}};

   logic          v_ff  [LAT];
   clb_item_type  it_ff [LAT];
   logic signed [QW-1:0] q_alo, q_ahi, q_blo, q_bhi;

   function automatic logic signed [QW-1:0] scl(input logic signed [CLB_COORD_W-1:0] v);
      return {{(QW-CLB_COORD_W-FRAC_BITS){v[CLB_COORD_W-1]}}, v, {FRAC_BITS{1'b0}}};
   endfunction

   function automatic logic signed [CLB_OUT_W-1:0] sat(input logic signed [QW-1:0] v);
      logic signed [CLB_OUT_W-1:0] r;
      priority if (v > SAT_HI) r = SAT_HI[CLB_OUT_W-1:0];
      else if (v < SAT_LO)     r = SAT_LO[CLB_OUT_W-1:0];
      else                     r = v[CLB_OUT_W-1:0];
      return r;
   endfunction

   clb_div #(.NW(NW), .DW(CLB_DEN_W)) u_div_alo (
      .clock(clock), .in_num({in_item.num_a_lo.mag, {FRAC_BITS{1'b0}}}),
      .in_den(in_item.den_a), .in_neg(in_item.num_a_lo.mag_neg), .quo(q_alo));
   clb_div #(.NW(NW), .DW(CLB_DEN_W)) u_div_ahi (
      .clock(clock), .in_num({in_item.num_a_hi.mag, {FRAC_BITS{1'b0}}}),
      .in_den(in_item.den_a), .in_neg(in_item.num_a_hi.mag_neg), .quo(q_ahi));
   clb_div #(.NW(NW), .DW(CLB_DEN_W)) u_div_blo (
      .clock(clock), .in_num({in_item.num_b_lo.mag, {FRAC_BITS{1'b0}}}),
      .in_den(in_item.den_b), .in_neg(in_item.num_b_lo.mag_neg), .quo(q_blo));
   clb_div #(.NW(NW), .DW(CLB_DEN_W)) u_div_bhi (
      .clock(clock), .in_num({in_item.num_b_hi.mag, {FRAC_BITS{1'b0}}}),
      .in_den(in_item.den_b), .in_neg(in_item.num_b_hi.mag_neg), .quo(q_bhi));

   // side band runs alongside the dividers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) v_ff[i] <= 1'b0;
      end else begin
         v_ff[0] <= in_valid;
         for (int i = 1; i < LAT; i++) v_ff[i] <= v_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      it_ff[0] <= in_item;
      for (int i = 1; i < LAT; i++) it_ff[i] <= it_ff[i-1];
   end

   clb_item_type           t;
   logic signed [QW-1:0]   qlx, qly, qhx, qhy;
   logic                   bs, es, ls, rs, ee, hit_in;
   logic signed [QW-1:0]   bx, by, ex, ey;
   logic                   hit_ff;
   logic signed [CLB_OUT_W-1:0] bx_ff, by_ff, ex_ff, ey_ff;
   logic                   vo_ff;

   always_comb begin
      t   = it_ff[LAT-1];
      qlx = scl(t.lx);
      qly = scl(t.ly);
      qhx = scl(t.hx);
      qhy = scl(t.hy);
      bs  = t.a_nz && q_alo >= qlx && q_alo <= qhx;
      es  = t.a_nz && q_ahi >= qlx && q_ahi <= qhx;
      ls  = q_blo >= qly && q_blo <= qhy;
      rs  = q_bhi >= qly && q_bhi <= qhy;
      bx  = q_alo;
      by  = qly;
      ex  = q_ahi;
      ey  = qhy;
      ee  = 1'b0;
      hit_in = 1'b0;
      if (bs && es) begin
         hit_in = 1'b1;
      end else begin
         // lone horizontal hit becomes the pending end point
         if (bs) begin
            ex = q_alo;
            ey = qly;
         end
         ee = bs || es;
         if (t.b_nz) begin
            if (ls && ee) begin
               hit_in = 1'b1;
               bx = qlx;
               by = q_blo;
            end else begin
               if (ls) begin
                  ex = qlx;
                  ey = q_blo;
                  ee = 1'b1;
               end
               bx = qhx;
               by = q_bhi;
               hit_in = rs && ee;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else begin
         vo_ff <= v_ff[LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      hit_ff <= hit_in;
      bx_ff  <= hit_in ? sat(bx) : '0;
      by_ff  <= hit_in ? sat(by) : '0;
      ex_ff  <= hit_in ? sat(ex) : '0;
      ey_ff  <= hit_in ? sat(ey) : '0;
   end

   assign out_valid = vo_ff;
   assign out_hit   = hit_ff;
   assign out_bx    = bx_ff;
   assign out_by    = by_ff;
   assign out_ex    = ex_ff;
   assign out_ey    = ey_ff;

endmodule

### rtl/clip_line_to_box_unit.sv
// top level of the line to box clipper
`timescale 1ns / 1ps
// usage
//   a line beat (req_coef_a, req_coef_b, req_coef_c) is taken on a clock edge
//   with start high and busy low; a new line may follow every cycle
//   each line gives exactly one result beat, shown for one cycle with
//   rsp_valid high; the receiver cannot hold results off
//   rsp_valid follows the line through the front stages, the queue, the divider
//   stages and the output register; throughput one line per cycle
//   most of the latency lies in the four pipelined restoring dividers in the back
//   end, one quotient bit per stage
//   the front end sorts the box corners and forms the edge numerators; a
//   four-entry queue sits between front and back; the back end never stalls,
//   so the queue holds at most one entry and busy stays low
//   box corners are written through the csr channel (index 0..3), always ready;
//   the user must write them only while no line is in flight, unenforced by the block
//   synchronous reset empties the pipeline and clears the corners to zero
module clip_line_to_box_unit
   import clb_pkg::*;
#(
   parameter int FRAC_BITS = CLB_FRAC_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [CLB_COORD_W-1:0] req_coef_a,
   input  logic signed [CLB_COORD_W-1:0] req_coef_b,
   input  logic signed [CLB_C_W-1:0]     req_coef_c,
   output logic                          rsp_valid,
   output logic                          rsp_hit,
   output logic signed [CLB_OUT_W-1:0]   rsp_begin_x,
   output logic signed [CLB_OUT_W-1:0]   rsp_begin_y,
   output logic signed [CLB_OUT_W-1:0]   rsp_end_x,
   output logic signed [CLB_OUT_W-1:0]   rsp_end_y,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [1:0]                    csr_index,
   input  logic [CLB_COORD_W-1:0]        csr_wdata
);

   localparam logic [1:0] REG_C1X = 2'd0;
   localparam logic [1:0] REG_C1Y = 2'd1;
   localparam logic [1:0] REG_C2X = 2'd2;
   localparam logic [1:0] REG_C2Y = 2'd3;

   logic signed [CLB_COORD_W-1:0] c1x_ff, c1y_ff, c2x_ff, c2y_ff;
   logic         accept;
   logic         fr_valid;
   clb_item_type fr_item;
   logic         q_ne, q_af;
   clb_item_type q_head;

   assign csr_ready = 1'b1;
   assign accept    = start && !busy;
   assign busy      = q_af;

   // corner registers
   always_ff @(posedge clock) begin
      if (reset) begin
         c1x_ff <= '0;
         c1y_ff <= '0;
         c2x_ff <= '0;
         c2y_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_C1X: c1x_ff <= csr_wdata;
            REG_C1Y: c1y_ff <= csr_wdata;
            REG_C2X: c2x_ff <= csr_wdata;
            REG_C2Y: c2y_ff <= csr_wdata;
            default: c2y_ff <= c2y_ff;
         endcase
      end
   end

   clb_front u_front (
      .clock(clock), .reset(reset), .in_valid(accept),
      .coef_a(req_coef_a), .coef_b(req_coef_b), .coef_c(req_coef_c),
      .c1x(c1x_ff), .c1y(c1y_ff), .c2x(c2x_ff), .c2y(c2y_ff),
      .out_valid(fr_valid), .out_item(fr_item));

   clb_fifo u_fifo (
      .clock(clock), .reset(reset), .push(fr_valid), .push_item(fr_item),
      .pop(q_ne), .not_empty(q_ne), .almost_full(q_af), .head_item(q_head));

   // back end never stalls, so the queue drains every cycle
   clb_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock(clock), .reset(reset), .in_valid(q_ne), .in_item(q_head),
      .out_valid(rsp_valid), .out_hit(rsp_hit),
      .out_bx(rsp_begin_x), .out_by(rsp_begin_y),
      .out_ex(rsp_end_x), .out_ey(rsp_end_y));

endmodule
